// ----- hdl/rce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_pkg: shared constants and types of the range coder encoder
// Bound constants, output buffer sizing and the buffer control/status words.
// ----------------------------------------------------------------------------
package rce_pkg;

    localparam int DataW        = 32;
    localparam int FieldW       = 16;
    localparam int CountBitsDef = 16;

    localparam int ByteMax    = 8;
    localparam int CntW       = $clog2(ByteMax + 1);
    localparam int IdxW       = $clog2(ByteMax);
    localparam int FlushBytes = 4;

    localparam int GuardSteps = 64;
    localparam int GuardW     = $clog2(GuardSteps);

    localparam logic [DataW-1:0] LowInit   = 32'h0000_0001;
    localparam logic [DataW-1:0] HighInit  = 32'hFFFF_FFFF;
    localparam logic [DataW-1:0] TopMask   = 32'hFF00_0000;
    localparam logic [DataW-1:0] SmallGap  = 32'h0001_0000;
    localparam logic [DataW-1:0] MarginGap = 32'h0000_1000;
    localparam logic [DataW-1:0] Margin    = 32'h0000_00FF;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       drain;
    } t_buf_ctl;

    typedef struct packed {
        logic [CntW-1:0] count;
        logic            drain_done;
    } t_buf_sts;

endpackage

// ----- hdl/rce_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_div: serial restoring divider
// Divides a 32-bit value by a count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rce_div import rce_pkg::*; #(
    parameter int CW = CountBitsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DataW-1:0] i_dividend,
    input  logic [CW-1:0]    i_divisor,
    output logic             o_done,
    output logic [DataW-1:0] o_quot
);

    localparam int StepW = $clog2(DataW);
    localparam logic [StepW-1:0] LastStep = StepW'(DataW - 1);

    logic             r_busy;
    logic             r_done;
    logic [StepW-1:0] r_step;
    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_dvs;
    logic [DataW-1:0] r_quot;

    logic [CW:0] w_sh;
    logic [CW:0] w_diff;
    logic        w_ge;

    assign w_sh   = {r_rem, r_quot[DataW-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            // restore or keep the partial remainder, shift in the quotient bit
            r_rem  <= w_ge ? w_diff[CW-1:0] : w_sh[CW-1:0];
            r_quot <= {r_quot[DataW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider restarted while busy");

endmodule

// ----- hdl/rce_obuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_obuf: output byte buffer
// Collects the bytes of one item, then drains them through an output register.
// ----------------------------------------------------------------------------
module rce_obuf import rce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_buf_ctl   i_ctl,
    output t_buf_sts   o_sts,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte
);

    logic [7:0]      r_mem [ByteMax];
    logic [CntW-1:0] r_cnt;
    logic [IdxW-1:0] r_rd;
    logic            r_valid;
    logic            r_done;
    logic [7:0]      r_byte;
    logic            r_last;

    logic w_load;
    logic w_final;

    assign w_load  = i_ctl.drain && (r_cnt != '0) && (!r_valid || i_ready);
    assign w_final = ({1'b0, r_rd} == (r_cnt - 1'b1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_rd    <= '0;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.push) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_valid <= 1'b1;
                if (w_final) begin
                    r_rd   <= '0;
                    r_cnt  <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_rd <= r_rd + 1'b1;
                end
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_cnt[IdxW-1:0]] <= i_ctl.push_byte;
        end
        if (w_load) begin
            r_byte <= r_mem[r_rd];
            r_last <= w_final;
        end
    end

    assign o_sts.count      = r_cnt;
    assign o_sts.drain_done = r_done;
    assign o_valid          = r_valid;
    assign o_out_byte       = r_byte;
    assign o_last_byte      = r_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(ByteMax))
        else $error("output buffer overfilled");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_cnt == '0) && (r_rd == '0))
        else $error("buffer not emptied after drain");

endmodule

// ----- hdl/range_coder_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_coder_encoder: 32-bit byte-wise range encoder
// Encode words narrow the bounds through a serial divider and one shared
// multiplier, then renormalise one step per cycle; flush words emit low.
// An encode divides, multiplies both counts, adds, renormalises and drains its
// bytes one per cycle while i_ready is high; a flush pushes four bytes of low
// and drains. The serial divider sets the rate; one word is in work at a time.
// Reset: synchronous, active low; bounds return to low 1, high all ones.
// ----------------------------------------------------------------------------
module range_coder_encoder import rce_pkg::*; #(
    parameter int COUNT_BITS = CountBitsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [FieldW-1:0] i_sym_low,
    input  logic [FieldW-1:0] i_sym_high,
    input  logic [FieldW-1:0] i_count_total,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_last_byte
);

    localparam int CW = COUNT_BITS;
    localparam int PW = DataW + CW;
    localparam logic [DataW-1:0] CntMask =
        (CW >= DataW) ? '1 : DataW'((64'd1 << CW) - 64'd1);
    localparam logic [GuardW-1:0] GuardLast = GuardW'(GuardSteps - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIV    = 8'b0000_0010,
        S_MUL_HI = 8'b0000_0100,
        S_MUL_LO = 8'b0000_1000,
        S_ADD_LO = 8'b0001_0000,
        S_RENORM = 8'b0010_0000,
        S_FLUSH  = 8'b0100_0000,
        S_DRAIN  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [DataW-1:0]  r_low, n_low;
    logic [DataW-1:0]  r_high, n_high;
    logic [DataW-1:0]  r_prod, n_prod;
    logic [GuardW-1:0] r_guard, n_guard;
    logic [CW-1:0]     r_lo_c, n_lo_c;
    logic [CW-1:0]     r_hi_c, n_hi_c;

    logic [DataW-1:0] w_lo_ext, w_hi_ext, w_tot_ext;
    logic [CW-1:0]    w_lo_c, w_hi_c, w_tot;
    logic             w_bad;
    logic             w_div_start;
    logic             w_div_done;
    logic [DataW-1:0] w_quot;
    logic [CW-1:0]    w_mul_op;
    logic [PW-1:0]    w_prod;
    logic [DataW-1:0] w_gap, w_mid;
    logic             w_stop;
    t_buf_ctl         w_ctl;
    t_buf_sts         w_sts;

    // mask the count fields to the configured count width
    assign w_lo_ext  = {{(DataW-FieldW){1'b0}}, i_sym_low} & CntMask;
    assign w_hi_ext  = {{(DataW-FieldW){1'b0}}, i_sym_high} & CntMask;
    assign w_tot_ext = {{(DataW-FieldW){1'b0}}, i_count_total} & CntMask;
    assign w_lo_c    = w_lo_ext[CW-1:0];
    assign w_hi_c    = w_hi_ext[CW-1:0];
    assign w_tot     = w_tot_ext[CW-1:0];
    assign w_bad     = (w_tot == '0) || (w_hi_c <= w_lo_c) || (w_hi_c > w_tot);

    assign o_ready = (r_state == S_IDLE);

    rce_div #(.CW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_high - r_low + 1'b1),
        .i_divisor  (w_tot),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // shared multiplier: high count first, then low count
    assign w_mul_op = (r_state == S_MUL_HI) ? r_hi_c : r_lo_c;
    assign w_prod   = {{CW{1'b0}}, w_quot} * {{DataW{1'b0}}, w_mul_op};

    assign w_gap = r_high - r_low;
    assign w_mid = {1'b0, r_high[DataW-1:1]} + {1'b0, r_low[DataW-1:1]};

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_high      = r_high;
        n_prod      = r_prod;
        n_guard     = r_guard;
        n_lo_c      = r_lo_c;
        n_hi_c      = r_hi_c;
        w_div_start = 1'b0;
        w_stop      = 1'b0;
        w_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_kind) begin
                        n_state = S_FLUSH;
                    end else if (!w_bad) begin
                        w_div_start = 1'b1;
                        n_lo_c      = w_lo_c;
                        n_hi_c      = w_hi_c;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL_HI;
                end
            end
            S_MUL_HI: begin
                n_prod  = w_prod[DataW-1:0];
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                n_high  = r_low + r_prod - 1'b1;
                n_prod  = w_prod[DataW-1:0];
                n_state = S_ADD_LO;
            end
            S_ADD_LO: begin
                n_low   = r_low + r_prod;
                n_guard = '0;
                n_state = S_RENORM;
            end
            S_RENORM: begin
                if ((r_high & TopMask) != (r_low & TopMask)) begin
                    if (w_gap >= SmallGap) begin
                        w_stop = 1'b1;
                    end else if (w_gap > MarginGap) begin
                        n_high = w_mid + Margin;
                        n_low  = w_mid - Margin;
                    end else begin
                        n_high = w_mid;
                        n_low  = w_mid;
                    end
                end else if (w_sts.count == CntW'(ByteMax)) begin
                    w_stop = 1'b1;
                end else begin
                    w_ctl.push      = 1'b1;
                    w_ctl.push_byte = r_low[DataW-1 -: 8];
                    n_high          = {r_high[DataW-9:0], 8'hFF};
                    n_low           = {r_low[DataW-9:0], 8'h00};
                    if (r_low[DataW-9:0] == '0) begin
                        n_low = LowInit;
                    end
                end
                n_guard = r_guard + 1'b1;
                if (w_stop || (r_guard == GuardLast)) begin
                    n_state = ((w_sts.count != '0) || w_ctl.push) ? S_DRAIN : S_IDLE;
                end
            end
            S_FLUSH: begin
                w_ctl.push      = 1'b1;
                w_ctl.push_byte = r_low[DataW-1 -: 8];
                n_low           = {r_low[DataW-9:0], 8'h00};
                if (w_sts.count == CntW'(FlushBytes - 1)) begin
                    n_low   = LowInit;
                    n_high  = HighInit;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                w_ctl.drain = 1'b1;
                if (w_sts.drain_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_low   <= LowInit;
            r_high  <= HighInit;
            r_guard <= '0;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_high  <= n_high;
            r_guard <= n_guard;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_lo_c <= n_lo_c;
        r_hi_c <= n_hi_c;
    end

    rce_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |-> (w_sts.count != CntW'(ByteMax)) && !w_ctl.drain)
        else $error("byte pushed into a full or draining buffer");

    a_flush_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind) |-> ##5
            ((r_state == S_DRAIN) && (w_sts.count == CntW'(FlushBytes))
             && (r_low == LowInit) && (r_high == HighInit)))
        else $error("flush did not stage four bytes and reset the bounds");

endmodule
